// ===== rtl/tcp_sender_congestion_window_defines.svh =====
// Assertion macros used by the congestion window checker.
// Needs nothing else; take in with a bare include.
`ifndef TCP_SENDER_CONGESTION_WINDOW_DEFINES_SVH
`define TCP_SENDER_CONGESTION_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define TSCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TSCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tscw_pkg.sv =====
// Types, codes and constants of the TCP sender congestion window.
// No dependencies; used by the top level and its checker.
package tscw_pkg;

   localparam int SEQ_BITS = 10;
   localparam int EXT_BITS = SEQ_BITS + 1;

   localparam logic [SEQ_BITS-1:0] CWND_MAX   = {SEQ_BITS{1'b1}};
   localparam logic [EXT_BITS-1:0] AVOID_MAX  = {EXT_BITS{1'b1}};
   localparam logic [3:0]          DUP_MAX    = 4'd15;
   localparam logic [SEQ_BITS-1:0] MIN_THRESH = SEQ_BITS'(2);

   localparam logic [SEQ_BITS-1:0] RST_INIT_WINDOW  = SEQ_BITS'(1);
   localparam logic [SEQ_BITS-1:0] RST_INIT_THRESH  = SEQ_BITS'(64);
   localparam logic [SEQ_BITS-1:0] RST_LAST_PACKET  = SEQ_BITS'(512);
   localparam logic [3:0]          RST_DUP_ACK_LIMIT = 4'd3;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_ACK     = 2'd1,
      OP_TIMEOUT = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_INITIAL_WINDOW    = 2'd0,
      CSR_INITIAL_THRESHOLD = 2'd1,
      CSR_LAST_PACKET       = 2'd2,
      CSR_DUP_ACK_LIMIT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [SEQ_BITS-1:0] ack_num;
   } req_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0] window;
      logic [SEQ_BITS-1:0] threshold;
      logic                in_slow_start;
      logic [EXT_BITS-1:0] next_expected_ack;
      logic [EXT_BITS-1:0] send_limit;
      logic [SEQ_BITS-1:0] resend_from;
      logic                send_now;
      logic                restart_timer;
      logic                transfer_done;
      logic                window_changed;
   } rsp_type;

endpackage

// ===== rtl/tcp_sender_congestion_window.sv =====
// Each result is written into the result buffer as its event is accepted.
// Throughput: one event per cycle; the whole update is one combinational
// pass from the connection state registers into a two-entry result buffer.
// Input stalls only while both result entries are full.
// Reset (synchronous, active high) loads the start-up connection state,
// the default register values and empties the result buffer.
module tcp_sender_congestion_window
   import tscw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [9:0]   csr_data
);

   // configuration
   logic [SEQ_BITS-1:0] init_window_ff, init_thresh_ff, last_packet_ff;
   logic [3:0]          dup_limit_ff;

   // connection state
   logic [SEQ_BITS-1:0] cwnd_ff, cwnd_in;
   logic [SEQ_BITS-1:0] ssthresh_ff, ssthresh_in;
   logic                slow_ff, slow_in;
   logic [EXT_BITS-1:0] avoid_ff, avoid_in;
   logic [EXT_BITS-1:0] expected_ff, expected_in;
   logic [EXT_BITS-1:0] limit_ff, limit_in;
   logic [SEQ_BITS-1:0] last_sent_ff, last_sent_in;
   logic [3:0]          dup_ff, dup_in;
   logic                active_ff, active_in;

   // result buffer
   rsp_type             slot0_ff, slot1_ff, result;
   logic [1:0]          count_ff;
   logic                push, pop;

   // shared arithmetic
   logic [SEQ_BITS-1:0] cwnd_bump;
   logic [SEQ_BITS-2:0] half;
   logic [SEQ_BITS-1:0] loss_thresh;
   logic [EXT_BITS-1:0] ack_ext, expected_m1;
   logic [EXT_BITS:0]   avoid_sum;
   logic [EXT_BITS-1:0] avoid_sat;
   logic [3:0]          dup_inc;
   logic                send, rearm, done, changed;

   assign csr_ready = 1'b1;
   assign req_stall = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign push      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_window_ff <= RST_INIT_WINDOW;
         init_thresh_ff <= RST_INIT_THRESH;
         last_packet_ff <= RST_LAST_PACKET;
         dup_limit_ff   <= RST_DUP_ACK_LIMIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_INITIAL_WINDOW:    init_window_ff <= csr_data;
            CSR_INITIAL_THRESHOLD: init_thresh_ff <= csr_data;
            CSR_LAST_PACKET:       last_packet_ff <= csr_data;
            CSR_DUP_ACK_LIMIT:     dup_limit_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign ack_ext     = {1'b0, req_data.ack_num};
   assign expected_m1 = expected_ff - EXT_BITS'(1);
   assign cwnd_bump   = (cwnd_ff < CWND_MAX) ? cwnd_ff + SEQ_BITS'(1) : cwnd_ff;
   assign half        = cwnd_ff[SEQ_BITS-1:1];
   assign loss_thresh = ({1'b0, half} > MIN_THRESH) ? {1'b0, half} : MIN_THRESH;
   // ack >= expected wherever this sum is used, so it never wraps
   assign avoid_sum   = {1'b0, avoid_ff} + {1'b0, ack_ext} - {1'b0, expected_ff}
                        + (EXT_BITS+1)'(1);
   assign avoid_sat   = (avoid_sum > {1'b0, AVOID_MAX}) ? AVOID_MAX
                                                         : avoid_sum[EXT_BITS-1:0];
   assign dup_inc     = (dup_ff < DUP_MAX) ? dup_ff + 4'd1 : dup_ff;

   always_comb begin
      cwnd_in      = cwnd_ff;
      ssthresh_in  = ssthresh_ff;
      slow_in      = slow_ff;
      avoid_in     = avoid_ff;
      expected_in  = expected_ff;
      limit_in     = limit_ff;
      last_sent_in = last_sent_ff;
      dup_in       = dup_ff;
      active_in    = active_ff;
      send         = 1'b0;
      rearm        = 1'b0;
      done         = 1'b0;
      changed      = 1'b0;
      case (opcode_type'(req_data.opcode))
         OP_START: begin
            cwnd_in      = (init_window_ff != '0) ? init_window_ff : SEQ_BITS'(1);
            ssthresh_in  = init_thresh_ff;
            slow_in      = 1'b1;
            avoid_in     = '0;
            expected_in  = EXT_BITS'(1);
            dup_in       = '0;
            last_sent_in = '0;
            limit_in     = {1'b0, cwnd_in};
            active_in    = 1'b1;
            send         = 1'b1;
            rearm        = 1'b1;
            changed      = 1'b1;
         end
         OP_ACK: begin
            if (active_ff) begin
               if (req_data.ack_num >= last_packet_ff) begin
                  expected_in = {1'b0, last_packet_ff} + EXT_BITS'(1);
                  active_in   = 1'b0;
                  done        = 1'b1;
               end else if (ack_ext >= expected_ff) begin
                  if (slow_ff) begin
                     cwnd_in  = cwnd_bump;
                     avoid_in = '0;
                     changed  = 1'b1;
                     if (cwnd_bump >= ssthresh_ff) begin
                        slow_in = 1'b0;
                     end
                  end else if (avoid_sat >= {1'b0, cwnd_ff}) begin
                     cwnd_in  = cwnd_bump;
                     avoid_in = '0;
                     changed  = 1'b1;
                  end else begin
                     avoid_in = avoid_sat;
                  end
                  expected_in = ack_ext + EXT_BITS'(1);
                  dup_in      = '0;
                  limit_in    = expected_in + {1'b0, cwnd_in} - EXT_BITS'(1);
                  send        = 1'b1;
                  rearm       = 1'b1;
               end else if (expected_ff != '0 && ack_ext == expected_m1) begin
                  dup_in = dup_inc;
                  if (dup_inc >= dup_limit_ff) begin
                     // fast retransmit: rewind to the duplicated ACK
                     last_sent_in = req_data.ack_num;
                     dup_in       = '0;
                     ssthresh_in  = loss_thresh;
                     cwnd_in      = SEQ_BITS'(1);
                     slow_in      = 1'b1;
                     limit_in     = expected_ff;
                     send         = 1'b1;
                     rearm        = 1'b1;
                     changed      = 1'b1;
                  end
               end
            end
         end
         OP_TIMEOUT: begin
            if (active_ff) begin
               last_sent_in = (expected_ff != '0) ? expected_m1[SEQ_BITS-1:0] : '0;
               dup_in       = '0;
               ssthresh_in  = loss_thresh;
               cwnd_in      = SEQ_BITS'(1);
               slow_in      = 1'b1;
               limit_in     = expected_ff;
               send         = 1'b1;
               rearm        = 1'b1;
               changed      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      result.window            = cwnd_in;
      result.threshold         = ssthresh_in;
      result.in_slow_start     = slow_in;
      result.next_expected_ack = expected_in;
      result.send_limit        = limit_in;
      result.resend_from       = last_sent_in;
      result.send_now          = send;
      result.restart_timer     = rearm;
      result.transfer_done     = done;
      result.window_changed    = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cwnd_ff      <= SEQ_BITS'(1);
         ssthresh_ff  <= RST_INIT_THRESH;
         slow_ff      <= 1'b1;
         avoid_ff     <= '0;
         expected_ff  <= EXT_BITS'(1);
         limit_ff     <= '0;
         last_sent_ff <= '0;
         dup_ff       <= '0;
         active_ff    <= 1'b0;
      end else if (push) begin
         cwnd_ff      <= cwnd_in;
         ssthresh_ff  <= ssthresh_in;
         slow_ff      <= slow_in;
         avoid_ff     <= avoid_in;
         expected_ff  <= expected_in;
         limit_ff     <= limit_in;
         last_sent_ff <= last_sent_in;
         dup_ff       <= dup_in;
         active_ff    <= active_in;
      end
   end

   // two-entry result buffer: slot0 is the head shown on the output
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == 2'd2) begin
            slot0_ff <= slot1_ff;
         end else if (push) begin
            slot0_ff <= result;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_ff <= result;
         end else begin
            slot1_ff <= result;
         end
      end
   end

endmodule

// ===== rtl/tscw_checker.sv =====
// Port-level checker for the TCP sender congestion window, bound to the top.
// Depends on tscw_pkg and tcp_sender_congestion_window_defines.svh.
`include "tcp_sender_congestion_window_defines.svh"

module tscw_checker
   import tscw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_type      rsp_data
);

   logic [EXT_BITS:0] limit_sum;
   logic              rsp_wait;
   logic              sending;
   logic              finishing;
   logic              limit_ok;
   logic              flags_quiet;
   logic              window_ok;

   assign limit_sum = {1'b0, rsp_data.next_expected_ack} + (EXT_BITS+1)'(rsp_data.window)
                      - (EXT_BITS+1)'(1);

   assign rsp_wait    = rsp_valid && rsp_stall;
   assign sending     = rsp_valid && rsp_data.send_now;
   assign finishing   = rsp_valid && rsp_data.transfer_done;
   assign limit_ok    = (limit_sum == {1'b0, rsp_data.send_limit});
   assign flags_quiet = !rsp_data.send_now && !rsp_data.restart_timer
                        && !rsp_data.window_changed;
   assign window_ok   = (rsp_data.window != '0)
                        && (rsp_data.restart_timer == rsp_data.send_now);

   `TSCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data), "item moved")
   `TSCW_ASSERT_NOW(a_limit_match, clock, reset, sending, limit_ok, "bad send limit")
   `TSCW_ASSERT_NOW(a_done_quiet, clock, reset, finishing, flags_quiet, "finish raised flags")
   `TSCW_ASSERT_NOW(a_window_nonzero, clock, reset, rsp_valid, window_ok, "bad window or rearm")

endmodule

bind tcp_sender_congestion_window tscw_checker u_tscw_checker (.*);
